/* rtl/assert_macros.svh */
// Assertion macros used by the checker file sfp_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked out of reset only.
`define SFP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfp assertion failed");

// Property checked on every edge, reset included.
`define SFP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sfp assertion failed");

`endif

/* rtl/sfp_pkg.sv */
// Shared widths, start byte reset value and byte role codes for the frame parser.
// No dependencies.
`timescale 1ns / 1ps

package sfp_pkg;

    localparam int ByteW = 8;
    localparam int RoleW = 3;

    localparam logic [ByteW-1:0] StartByteRst = 8'd254;

    localparam logic [RoleW-1:0] ROLE_TEXT  = 3'd0;
    localparam logic [RoleW-1:0] ROLE_START = 3'd1;
    localparam logic [RoleW-1:0] ROLE_LEN   = 3'd2;
    localparam logic [RoleW-1:0] ROLE_CMD0  = 3'd3;
    localparam logic [RoleW-1:0] ROLE_CMD1  = 3'd4;
    localparam logic [RoleW-1:0] ROLE_DATA  = 3'd5;
    localparam logic [RoleW-1:0] ROLE_GOOD  = 3'd6;
    localparam logic [RoleW-1:0] ROLE_BAD   = 3'd7;

endpackage

/* rtl/sof_frame_parser_xor_check_unit.sv */
// An input request reaches the result through the input register and the result register.
// Throughput: one byte per cycle while the output is not stalled; the parse state and XOR update together.
// An output stall blocks input only once both registers hold a request; s_axis_tready
// then follows m_axis_tready.
// Reset (rst_n low, asynchronous): both stages empty, parser waiting for start byte,
// count and check cleared, start byte register back to 0xFE.
`timescale 1ns / 1ps

module sof_frame_parser_xor_check_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sfp_pkg::ByteW-1:0]   cfg_wr_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sfp_pkg::ByteW-1:0]   s_axis_tdata,    // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [2*sfp_pkg::ByteW-1:0] m_axis_tdata,    // [7:0] out_byte, [15:8] bytes_left
    output logic [sfp_pkg::RoleW-1:0]   m_axis_tuser     // [2:0] byte_role
);
    import sfp_pkg::*;

    localparam logic [2:0] MODE_WAIT  = 3'd0;
    localparam logic [2:0] MODE_LEN   = 3'd1;
    localparam logic [2:0] MODE_CMD0  = 3'd2;
    localparam logic [2:0] MODE_CMD1  = 3'd3;
    localparam logic [2:0] MODE_DATA  = 3'd4;
    localparam logic [2:0] MODE_CHECK = 3'd5;

    logic [ByteW-1:0] start_val_reg;
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic [2:0]       mode_reg,  mode_next;
    logic [ByteW-1:0] count_reg, count_next;
    logic [ByteW-1:0] check_reg, check_next;
    logic             out_valid_reg;
    logic [ByteW-1:0] out_byte_reg;
    logic [RoleW-1:0] role_reg,  role_next;
    logic [ByteW-1:0] left_reg,  left_next;
    logic             advance;
    logic             process;
    logic [ByteW-1:0] dec_count;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {left_reg, out_byte_reg};
    assign m_axis_tuser  = role_reg;

    assign dec_count = (count_reg != '0) ? count_reg - 1'b1 : count_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        check_next = check_reg;
        role_next  = ROLE_TEXT;
        left_next  = '0;
        case (mode_reg)
            MODE_LEN:
            begin
                check_next = in_byte_reg;
                count_next = in_byte_reg;
                left_next  = in_byte_reg;
                role_next  = ROLE_LEN;
                mode_next  = MODE_CMD0;
            end
            MODE_CMD0:
            begin
                check_next = check_reg ^ in_byte_reg;
                left_next  = count_reg;
                role_next  = ROLE_CMD0;
                mode_next  = MODE_CMD1;
            end
            MODE_CMD1:
            begin
                check_next = check_reg ^ in_byte_reg;
                left_next  = count_reg;
                role_next  = ROLE_CMD1;
                mode_next  = (count_reg != '0) ? MODE_DATA : MODE_CHECK;
            end
            MODE_DATA:
            begin
                check_next = check_reg ^ in_byte_reg;
                count_next = dec_count;
                left_next  = dec_count;
                role_next  = ROLE_DATA;
                mode_next  = (dec_count == '0) ? MODE_CHECK : MODE_DATA;
            end
            MODE_CHECK:
            begin
                role_next = (in_byte_reg == check_reg) ? ROLE_GOOD : ROLE_BAD;
                mode_next = MODE_WAIT;
            end
            default:
            begin
                if (in_byte_reg == start_val_reg)
                begin
                    role_next  = ROLE_START;
                    check_next = '0;
                    count_next = '0;
                    mode_next  = MODE_LEN;
                end
                else
                begin
                    role_next = ROLE_TEXT;
                    mode_next = MODE_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_val_reg  <= StartByteRst;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_WAIT;
            count_reg      <= '0;
            check_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                start_val_reg <= cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (process)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                check_reg <= check_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
        if (process)
        begin
            out_byte_reg <= in_byte_reg;
            role_reg     <= role_next;
            left_reg     <= left_next;
        end
    end

endmodule

/* rtl/sfp_checker.sv */
// Port-level checker for the frame parser, bound to the top level.
// Depends on sfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [2*sfp_pkg::ByteW-1:0] m_axis_tdata,
    input logic [sfp_pkg::RoleW-1:0]   m_axis_tuser
);
    import sfp_pkg::*;

    logic [ByteW-1:0] obs_byte;
    logic [ByteW-1:0] obs_left;
    logic             no_count_role;

    assign obs_byte = m_axis_tdata[ByteW-1:0];
    assign obs_left = m_axis_tdata[2*ByteW-1:ByteW];
    assign no_count_role = (m_axis_tuser == ROLE_TEXT) || (m_axis_tuser == ROLE_START)
                        || (m_axis_tuser == ROLE_GOOD) || (m_axis_tuser == ROLE_BAD);

    `SFP_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !m_axis_tvalid)
    `SFP_ASSERT(a_valid_held, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `SFP_ASSERT(a_left_zero, clk, rst_n, m_axis_tvalid && no_count_role |-> obs_left == '0)
    `SFP_ASSERT(a_len_left, clk, rst_n,
        m_axis_tvalid && m_axis_tuser == ROLE_LEN |-> obs_left == obs_byte)

endmodule

bind sof_frame_parser_xor_check_unit sfp_checker u_sfp_checker (.*);
